FILE: sv/blr_pkg.sv
// ----------------------------------------------------------------------------
// blr_pkg
// Shared types and constants of the line rasterizer: coordinate width,
// command codes and the input and result transfer structs.
// ----------------------------------------------------------------------------
package blr_pkg;

    localparam int COORD_BITS = 12;
    localparam int ERR_BITS   = COORD_BITS + 2;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic        [COORD_BITS-1:0] t_extent;
    typedef logic signed [ERR_BITS-1:0]   t_err;

    typedef struct packed {
        logic   command;
        t_coord start_x;
        t_coord start_y;
        t_coord end_x;
        t_coord end_y;
    } t_in_item;

    typedef struct packed {
        t_coord pixel_x;
        t_coord pixel_y;
        logic   last;
    } t_out_item;

endpackage

FILE: sv/bresenham_line_rasterizer.sv
// ----------------------------------------------------------------------------
// bresenham_line_rasterizer
// Integer line rasterizer: a begin transfer loads two endpoints, each step
// transfer returns the next pixel of the line.
//
// input channel: i_in_valid / o_in_ready carry i_in_data; command selects
//   begin (endpoints, no result) or step (one pixel while a line is open)
// output channel: o_out_valid / i_out_ready carry o_out_data; last marks the
//   final endpoint, after which steps return nothing until the next begin
// a step's pixel is registered in the result queue before it is presented
// throughput: one transfer per cycle while the result queue has space, set by
//   the add-compare update of the decision term
// a begin while a line is open drops that line and starts the new one
// reset: no line open, result queue empty
// stall: a two-entry queue holds pixels; o_in_ready drops only while both
//   entries wait on the receiver
// ----------------------------------------------------------------------------
module bresenham_line_rasterizer import blr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      take, emit, space;
    t_out_item pixel;

    assign o_in_ready = space;
    assign take       = i_in_valid && space;

    blr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_data),
        .o_emit  (emit),
        .o_pixel (pixel)
    );

    blr_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (emit),
        .i_data  (pixel),
        .o_space (space),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

FILE: sv/blr_core.sv
// ----------------------------------------------------------------------------
// blr_core
// Line setup and per-pixel stepping: endpoint ordering, axis selection and
// the decision-variable update, one item per cycle while i_take is high.
// ----------------------------------------------------------------------------
module blr_core import blr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_take,
    input  t_in_item  i_item,
    output logic      o_emit,
    output t_out_item o_pixel
);

    t_coord  r_cur_x, r_cur_y, r_major_end;
    t_err    r_error_term;
    t_extent r_delta_major, r_delta_minor;
    logic    r_steep, r_y_descending, r_busy;

    t_coord  n_cur_x, n_cur_y, n_major_end;
    t_err    n_error_term;
    t_extent n_delta_major, n_delta_minor;
    logic    n_steep, n_y_descending, n_busy;

    // setup terms
    logic                      swap;
    t_coord                    x0, y0, x1, y1;
    logic signed [COORD_BITS:0] dx_w, dy_w, ady_w;
    t_extent                   dx, ady;
    logic                      s_steep, s_desc;
    t_extent                   s_dmaj, s_dmin;

    // step terms
    t_coord major_cur;
    logic   last, go, strict;
    t_err   two_min, two_maj;

    always_comb begin
        swap   = i_item.end_x < i_item.start_x;
        x0     = swap ? i_item.end_x   : i_item.start_x;
        y0     = swap ? i_item.end_y   : i_item.start_y;
        x1     = swap ? i_item.start_x : i_item.end_x;
        y1     = swap ? i_item.start_y : i_item.end_y;
        dx_w   = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
        dy_w   = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
        s_desc = dy_w[COORD_BITS];
        ady_w  = s_desc ? -dy_w : dy_w;
        dx     = dx_w[COORD_BITS-1:0];
        ady    = ady_w[COORD_BITS-1:0];
        s_steep = ady >= dx;
        s_dmaj  = s_steep ? ady : dx;
        s_dmin  = s_steep ? dx  : ady;
    end

    always_comb begin
        major_cur = r_steep ? r_cur_y : r_cur_x;
        last      = major_cur == r_major_end;
        strict    = !r_steep && r_y_descending;
        go        = !r_error_term[ERR_BITS-1] && (!strict || (r_error_term != '0));
        two_min   = $signed({1'b0, r_delta_minor, 1'b0});
        two_maj   = $signed({1'b0, r_delta_major, 1'b0});
    end

    assign o_emit          = i_take && (i_item.command == CMD_STEP) && r_busy;
    assign o_pixel.pixel_x = r_cur_x;
    assign o_pixel.pixel_y = r_cur_y;
    assign o_pixel.last    = last;

    always_comb begin
        n_cur_x        = r_cur_x;
        n_cur_y        = r_cur_y;
        n_major_end    = r_major_end;
        n_error_term   = r_error_term;
        n_delta_major  = r_delta_major;
        n_delta_minor  = r_delta_minor;
        n_steep        = r_steep;
        n_y_descending = r_y_descending;
        n_busy         = r_busy;
        if (i_take && (i_item.command == CMD_BEGIN)) begin
            n_cur_x        = x0;
            n_cur_y        = y0;
            n_major_end    = s_steep ? y1 : x1;
            n_delta_major  = s_dmaj;
            n_delta_minor  = s_dmin;
            n_steep        = s_steep;
            n_y_descending = s_desc;
            n_error_term   = $signed({1'b0, s_dmin, 1'b0}) - $signed({2'b00, s_dmaj});
            n_busy         = 1'b1;
        end else if (o_emit) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_error_term = r_error_term + two_min - (go ? two_maj : t_err'(0));
                if (r_steep) begin
                    n_cur_y = r_y_descending ? r_cur_y - t_coord'(1) : r_cur_y + t_coord'(1);
                    if (go) begin
                        n_cur_x = r_cur_x + t_coord'(1);
                    end
                end else begin
                    n_cur_x = r_cur_x + t_coord'(1);
                    if (go) begin
                        n_cur_y = r_y_descending ? r_cur_y - t_coord'(1)
                                                 : r_cur_y + t_coord'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_major_end    <= '0;
            r_error_term   <= '0;
            r_delta_major  <= '0;
            r_delta_minor  <= '0;
            r_steep        <= 1'b0;
            r_y_descending <= 1'b0;
            r_busy         <= 1'b0;
        end else begin
            r_cur_x        <= n_cur_x;
            r_cur_y        <= n_cur_y;
            r_major_end    <= n_major_end;
            r_error_term   <= n_error_term;
            r_delta_major  <= n_delta_major;
            r_delta_minor  <= n_delta_minor;
            r_steep        <= n_steep;
            r_y_descending <= n_y_descending;
            r_busy         <= n_busy;
        end
    end

endmodule

FILE: sv/blr_oq.sv
// ----------------------------------------------------------------------------
// blr_oq
// Two-entry result queue: registers each pixel and holds a second one while
// the receiver stalls, so the input side keeps moving until both are full.
// ----------------------------------------------------------------------------
module blr_oq import blr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_out_item i_data,
    output logic      o_space,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic [1:0] r_count, n_count;
    t_out_item  r_slot0, r_slot1, n_slot0, n_slot1;
    logic       pop;

    assign o_space = r_count != 2'd2;
    assign o_valid = r_count != 2'd0;
    assign o_data  = r_slot0;
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_count = r_count;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        case ({i_push, pop})
            2'b10: begin
                if (r_count == 2'd0) begin
                    n_slot0 = i_data;
                end else begin
                    n_slot1 = i_data;
                end
                n_count = r_count + 2'd1;
            end
            2'b01: begin
                n_slot0 = r_slot1;
                n_count = r_count - 2'd1;
            end
            2'b11: begin
                if (r_count == 2'd1) begin
                    n_slot0 = i_data;
                end else begin
                    n_slot0 = r_slot1;
                    n_slot1 = i_data;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

endmodule
